// ----- rtl/core/cht_pkg.sv -----
// Package for the chained hash table unit: sizes, operation and status codes,
// controller states, command and status structs, and the bucket hash. No dependencies.
package cht_pkg;
  localparam int unsigned Buckets = 256;
  localparam int unsigned Nodes = 256;
  localparam int unsigned KeyBits = 32;
  localparam int unsigned BktW = $clog2(Buckets);
  localparam int unsigned NodeW = $clog2(Nodes);
  localparam int unsigned LinkW = $clog2(Nodes + 1);
  localparam logic [LinkW-1:0] LinkNull = LinkW'(Nodes);

  typedef enum logic [1:0] {
    FuncInsert = 2'd0,
    FuncFind   = 2'd1,
    FuncRemove = 2'd2,
    FuncNone   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StatDone     = 2'd0,
    StatNotFound = 2'd1,
    StatFull     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StHead,
    StRead,
    StCmp,
    StFin
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture request
    logic rd_head;  // read bucket head
    logic rd_node;  // read current node
    logic step;     // advance to next node
    logic finish;   // apply update and emit result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic cur_null;
    logic hit;
    logic steps_done;
  } stat_t;

  function automatic logic [BktW-1:0] bucket_of(logic [KeyBits-1:0] k);
    logic [63:0] kk;
    logic [15:0] f;
    kk = 64'(k);
    f = kk[15:0] ^ kk[31:16] ^ kk[47:32] ^ kk[63:48];
    return BktW'(32'(f) % Buckets);
  endfunction
endpackage

// ----- rtl/core/chained_hash_table_unit.sv -----
// Chained hash table unit: insert, find and remove over separately chained
// buckets. After the bucket head read, each chain node visited takes one node
// read and one compare; an empty chain still takes one such pass, then the
// final update emits done_o. busy_o falls as done_o rises, so a new request is
// taken only once the last one is done; the receiver cannot stall results.
// Reset empties all buckets, the free list and the pool at once.
module chained_hash_table_unit import cht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] result_value_o
);
  cmd_t  cmd;
  stat_t stat;

  // The controller sequences head read, the chain walk and the final update.
  cht_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .stat_i(stat), .cmd_o(cmd), .busy_o
  );

  // The datapath holds all storage and emits the one-cycle result strobe.
  cht_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .func_i, .key_i, .value_i,
    .stat_o(stat), .done_o, .status_o, .result_value_o
  );
endmodule

// ----- rtl/core/cht_ctrl.sv -----
// Controller state machine for the chained hash table unit.
// Depends on cht_pkg.
module cht_ctrl import cht_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (start_i) state_d = StHead;
      StHead: state_d = StRead;
      StRead: state_d = StCmp;
      StCmp: begin
        if (stat_i.cur_null || stat_i.hit || stat_i.steps_done) state_d = StFin;
        else state_d = StRead;
      end
      StFin: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = (state_q != StIdle);
    unique case (state_q)
      StIdle: cmd_o.load = start_i;
      StHead: cmd_o.rd_head = 1'b1;
      StRead: cmd_o.rd_node = 1'b1;
      StCmp: cmd_o.step = !(stat_i.cur_null || stat_i.hit || stat_i.steps_done);
      StFin: cmd_o.finish = 1'b1;
      default: ;
    endcase
  end
endmodule

// ----- rtl/core/cht_dp.sv -----
// Datapath of the chained hash table unit: bucket heads, node memories,
// free list and pool count. Depends on cht_pkg.
module cht_dp import cht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [1:0]  func_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output stat_t       stat_o,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] result_value_o
);
  logic [LinkW-1:0]   head_mem [Buckets];
  logic [Buckets-1:0] head_vld_q;
  logic [KeyBits-1:0] key_mem  [Nodes];
  logic [31:0]        val_mem  [Nodes];
  logic [LinkW-1:0]   link_mem [Nodes];

  func_e              func_q;
  logic [KeyBits-1:0] key_q;
  logic [31:0]        val_q;
  logic [BktW-1:0]    bkt_q;
  logic [LinkW-1:0]   cur_q, prev_q, head_rd_q;
  logic [KeyBits-1:0] rd_key_q;
  logic [31:0]        rd_val_q;
  logic [LinkW-1:0]   rd_link_q;
  logic [LinkW-1:0]   steps_q;
  logic [LinkW-1:0]   fresh_q, free_q;
  logic               hit_q;  // cur_q matched when finishing
  logic               head_rd_pend_q;

  logic               done_q;
  logic [1:0]         status_q;
  logic [31:0]        res_q;

  logic [LinkW-1:0] head_val;
  assign head_val = head_vld_q[bkt_q] ? head_rd_q : LinkNull;

  // The first node of a chain is read straight from the head value, since
  // cur_q only takes the head at the end of that read cycle.
  logic [NodeW-1:0] rd_addr;
  assign rd_addr = head_rd_pend_q ? head_val[NodeW-1:0] : cur_q[NodeW-1:0];

  assign stat_o.cur_null = (cur_q == LinkNull);
  assign stat_o.hit = !stat_o.cur_null && (rd_key_q == key_q);
  assign stat_o.steps_done = (steps_q == LinkW'(Nodes));

  // Free list head's link is needed for insert; free_q node link read later.
  logic [LinkW-1:0] free_link_q;

  always_ff @(posedge clk_i) begin
    head_rd_q <= head_mem[bkt_q];
    free_link_q <= link_mem[free_q[NodeW-1:0]];
    if (cmd_i.rd_node) begin
      rd_key_q  <= key_mem[rd_addr];
      rd_val_q  <= val_mem[rd_addr];
      rd_link_q <= link_mem[rd_addr];
    end
    if (cmd_i.load) begin
      func_q <= func_e'(func_i);
      key_q  <= key_i[KeyBits-1:0];
      val_q  <= value_i;
      bkt_q  <= bucket_of(key_i[KeyBits-1:0]);
    end
  end

  // Memory writes at finish.
  logic             ins_new, ins_ok, rem_ok;
  logic [NodeW-1:0] new_n;
  logic             use_free;
  always_comb begin
    use_free = (free_q != LinkNull);
    new_n = use_free ? free_q[NodeW-1:0] : fresh_q[NodeW-1:0];
    ins_new = cmd_i.finish && func_q == FuncInsert && !hit_q;
    ins_ok = ins_new && (use_free || fresh_q != LinkW'(Nodes));
    rem_ok = cmd_i.finish && func_q == FuncRemove && hit_q;
  end

  // Result of the request being finished.
  logic [1:0]  status_d;
  logic [31:0] res_d;
  always_comb begin
    status_d = StatDone;
    res_d = '0;
    unique case (func_q)
      FuncInsert: begin
        if (hit_q || ins_ok) res_d = val_q;
        else status_d = StatFull;
      end
      FuncFind: begin
        if (hit_q) res_d = rd_val_q;
        else status_d = StatNotFound;
      end
      FuncRemove: begin
        if (!hit_q) status_d = StatNotFound;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && func_q == FuncInsert && hit_q) val_mem[cur_q[NodeW-1:0]] <= val_q;
    if (ins_ok) begin
      key_mem[new_n]  <= key_q;
      val_mem[new_n]  <= val_q;
      link_mem[new_n] <= head_val;
    end
    if (rem_ok) begin
      if (prev_q != LinkNull) link_mem[prev_q[NodeW-1:0]] <= rd_link_q;
      link_mem[cur_q[NodeW-1:0]] <= free_q;
    end
    if (ins_ok) head_mem[bkt_q] <= LinkW'(new_n);
    else if (rem_ok && prev_q == LinkNull) head_mem[bkt_q] <= rd_link_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
      fresh_q <= '0;
      free_q <= LinkNull;
      cur_q <= LinkNull;
      prev_q <= LinkNull;
      steps_q <= '0;
      hit_q <= 1'b0;
      head_rd_pend_q <= 1'b0;
      done_q <= 1'b0;
      status_q <= StatDone;
      res_q <= '0;
    end else begin
      done_q <= cmd_i.finish;
      head_rd_pend_q <= cmd_i.rd_head;
      if (cmd_i.rd_head) begin
        prev_q <= LinkNull;
        steps_q <= '0;
      end
      // Head data is valid the cycle after rd_head, while the first node is
      // read, so cur_q takes the head at the end of that cycle.
      if (head_rd_pend_q) cur_q <= head_val;
      if (cmd_i.step) begin
        prev_q <= cur_q;
        cur_q <= rd_link_q;
        steps_q <= steps_q + 1'b1;
      end
      // A match only counts once the compared node data belongs to cur_q.
      if (cmd_i.rd_head) hit_q <= 1'b0;
      else if (stat_o.hit && !head_rd_pend_q && !cmd_i.step && !cmd_i.finish) hit_q <= 1'b1;
      if (cmd_i.finish) begin
        status_q <= status_d;
        res_q <= res_d;
        if (ins_ok) begin
          head_vld_q[bkt_q] <= 1'b1;
          if (use_free) free_q <= free_link_q;
          else fresh_q <= fresh_q + 1'b1;
        end
        if (rem_ok) begin
          free_q <= cur_q;
          if (prev_q == LinkNull) head_vld_q[bkt_q] <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign status_o = status_q;
  assign result_value_o = res_q;
endmodule
